// ----- src/sphere_wall_doorway_collision_defines.svh -----
// Assertion macros for the sphere and doorway wall collision block.
`ifndef SPHERE_WALL_DOORWAY_COLLISION_DEFINES_SVH
`define SPHERE_WALL_DOORWAY_COLLISION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SWDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SWDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/swdc_pkg.sv -----
// Shared types, constants and codes of the sphere and doorway wall collision block.
package swdc_pkg;

    // Door table depth
    localparam int MAX_DOORS = 8;

    // Queue depths and their counter widths
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUTQ_DEPTH  = 4;
    localparam int OPTR_W      = $clog2(OUTQ_DEPTH);
    localparam int OCNT_W      = $clog2(OUTQ_DEPTH + 1);

    // Configuration port
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_BASE_Y     = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] REG_DIR_COS    = 3'd3;
    localparam logic [2:0] REG_DIR_SIN    = 3'd4;
    localparam logic [2:0] REG_LENGTH     = 3'd5;
    localparam logic [2:0] REG_HEIGHT     = 3'd6;
    localparam logic [2:0] REG_DOOR_COUNT = 3'd7;

    // Result reason codes
    typedef enum logic [2:0] {
        OC_VERT = 3'd0,
        OC_END  = 3'd1,
        OC_FAR  = 3'd2,
        OC_DOOR = 3'd3,
        OC_HIT  = 3'd4,
        OC_LOAD = 3'd5
    } outcome_t;

    // Wall configuration
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] base_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_cos;
        logic signed [15:0] dir_sin;
        logic [30:0]        length;
        logic [30:0]        height;
        logic [3:0]         door_count;
    } cfg_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic               mode;
        logic [2:0]         door_index;
        logic [30:0]        door_start;
        logic [30:0]        door_width;
        logic signed [31:0] door_height;
        logic               vclear;
        logic signed [32:0] dx;
        logic signed [32:0] dz;
        logic signed [31:0] sy;
        logic [30:0]        radius;
    } item_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic push;
        logic full;
    } qwr_t;

    // One result
    typedef struct packed {
        logic     collides;
        outcome_t outcome;
    } result_t;

endpackage

// ----- src/swdc_front.sv -----
// Front stage: accepts items, does the height test and forms the offsets from the wall start.
module swdc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swdc_pkg::cfg_t       cfg,
    input  logic                 push,
    output logic                 full,
    input  logic                 mode,
    input  logic [2:0]           door_index,
    input  logic [30:0]          door_start,
    input  logic [30:0]          door_width,
    input  logic signed [31:0]   door_height,
    input  logic signed [31:0]   sphere_x,
    input  logic signed [31:0]   sphere_y,
    input  logic signed [31:0]   sphere_z,
    input  logic [30:0]          sphere_radius,
    output swdc_pkg::qwr_t       qwr_out,
    input  logic                 q_full,
    output swdc_pkg::item_t      item
);

    logic               valid_reg;
    swdc_pkg::item_t    item_reg;
    swdc_pkg::item_t    item_next;
    logic               adv;
    logic signed [33:0] sy34;
    logic signed [33:0] r34;
    logic signed [33:0] base34;
    logic signed [33:0] top34;

    // Stage moves when empty or when the queue takes its item
    assign adv  = !valid_reg || !q_full;
    assign full = !adv;

    // Height band test, widened so nothing wraps
    assign sy34   = 34'(sphere_y);
    assign r34    = $signed({3'b000, sphere_radius});
    assign base34 = 34'(cfg.base_y);
    assign top34  = base34 + $signed({3'b000, cfg.height});

    always_comb
    begin
        item_next             = '0;
        item_next.mode        = mode;
        item_next.door_index  = door_index;
        item_next.door_start  = door_start;
        item_next.door_width  = door_width;
        item_next.door_height = door_height;
        item_next.vclear      = (sy34 + r34 < base34) || (sy34 - r34 > top34);
        item_next.dx          = 33'(sphere_x) - 33'(cfg.origin_x);
        item_next.dz          = 33'(sphere_z) - 33'(cfg.origin_z);
        item_next.sy          = sphere_y;
        item_next.radius      = sphere_radius;
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= push;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (push && adv)
        begin
            item_reg <= item_next;
        end
    end

    assign qwr_out.push = valid_reg && !q_full;
    assign qwr_out.full = full;
    assign item         = item_reg;

endmodule

// ----- src/swdc_queue.sv -----
// Short item queue that decouples the front stage from the back pipeline.
module swdc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  swdc_pkg::item_t wr_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output swdc_pkg::item_t rd_item
);

    swdc_pkg::item_t                 mem [swdc_pkg::QUEUE_DEPTH];
    logic [swdc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [swdc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [swdc_pkg::QCNT_W-1:0]     count_reg;
    logic                            do_wr;
    logic                            do_rd;

    assign full  = (count_reg == swdc_pkg::QCNT_W'(swdc_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = mem[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == swdc_pkg::QPTR_W'(swdc_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == swdc_pkg::QPTR_W'(swdc_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/swdc_back.sv -----
// Back pipeline: projections onto the wall, end, distance and doorway tests, result queue.
module swdc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  swdc_pkg::cfg_t   cfg,
    input  swdc_pkg::item_t  q_item,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output swdc_pkg::result_t result
);

    // Pipeline registers
    logic                s1_valid_reg;
    swdc_pkg::item_t     s1_item_reg;
    logic                s2_valid_reg;
    swdc_pkg::item_t     s2_item_reg;
    logic signed [48:0]  pcx_reg;
    logic signed [48:0]  psz_reg;
    logic signed [48:0]  pcz_reg;
    logic signed [48:0]  psx_reg;
    logic                s3_valid_reg;
    swdc_pkg::item_t     s3_item_reg;
    logic signed [49:0]  along_reg;
    logic [49:0]         across_reg;

    // Door tables
    logic [30:0]         start_tab [swdc_pkg::MAX_DOORS];
    logic [30:0]         width_tab [swdc_pkg::MAX_DOORS];
    logic signed [31:0]  height_tab [swdc_pkg::MAX_DOORS];

    // Result queue
    swdc_pkg::result_t           oq_mem [swdc_pkg::OUTQ_DEPTH];
    logic [swdc_pkg::OPTR_W-1:0] oq_wr_ptr_reg;
    logic [swdc_pkg::OPTR_W-1:0] oq_rd_ptr_reg;
    logic [swdc_pkg::OCNT_W-1:0] oq_count_reg;

    logic                oq_full;
    logic                oq_wr;
    logic                oq_rd;
    logic                adv;
    logic signed [49:0]  along_next;
    logic signed [49:0]  across_signed;
    logic signed [50:0]  along51;
    logic signed [50:0]  rs51;
    logic signed [50:0]  lenr51;
    logic [31:0]         lenr;
    logic                end_clear;
    logic                far_clear;
    logic signed [32:0]  sy33;
    logic [swdc_pkg::MAX_DOORS-1:0] door_hit;
    swdc_pkg::result_t   res_next;

    // Whole pipeline stalls only when its last stage cannot drain
    assign oq_full = (oq_count_reg == swdc_pkg::OCNT_W'(swdc_pkg::OUTQ_DEPTH));
    assign adv     = !s3_valid_reg || !oq_full;
    assign q_pop   = adv && !q_empty;
    assign oq_wr   = s3_valid_reg && !oq_full;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= !q_empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1 to 2: direction times offset, four products
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg <= q_item;
        end
        if (adv)
        begin
            s2_item_reg <= s1_item_reg;
            pcx_reg     <= 49'(cfg.dir_cos) * 49'(s1_item_reg.dx);
            psz_reg     <= 49'(cfg.dir_sin) * 49'(s1_item_reg.dz);
            pcz_reg     <= 49'(cfg.dir_cos) * 49'(s1_item_reg.dz);
            psx_reg     <= 49'(cfg.dir_sin) * 49'(s1_item_reg.dx);
        end
    end

    // Stage 2 to 3: distance along and across the wall, Q.30
    assign along_next    = 50'(pcx_reg) + 50'(psz_reg);
    assign across_signed = 50'(pcz_reg) - 50'(psx_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_item_reg <= s2_item_reg;
            along_reg   <= along_next;
            across_reg  <= across_signed[49] ? 50'(-across_signed) : 50'(across_signed);
        end
    end

    // Stage 3: end and distance tests against radius scaled to Q.30
    assign along51   = 51'(along_reg);
    assign rs51      = $signed({6'b0, s3_item_reg.radius, 14'b0});
    assign lenr      = {1'b0, cfg.length} + {1'b0, s3_item_reg.radius};
    assign lenr51    = $signed({5'b0, lenr, 14'b0});
    assign end_clear = (along51 < -rs51) || (along51 > lenr51);
    assign far_clear = across_reg > {5'b0, s3_item_reg.radius, 14'b0};
    assign sy33      = 33'(s3_item_reg.sy);

    // One comparator set per door entry
    for (genvar d = 0; d < swdc_pkg::MAX_DOORS; d++)
    begin : g_door
        logic [31:0]        span_end;
        logic signed [50:0] lo51;
        logic signed [50:0] hi51;
        logic signed [32:0] hlim;

        assign span_end = {1'b0, start_tab[d]} + {1'b0, width_tab[d]};
        assign lo51     = $signed({6'b0, start_tab[d], 14'b0});
        assign hi51     = $signed({5'b0, span_end, 14'b0});
        assign hlim     = 33'(height_tab[d]) - $signed({2'b00, s3_item_reg.radius});
        assign door_hit[d] = (int'(cfg.door_count) > d) && (along51 > lo51)
                             && (along51 < hi51) && (sy33 < hlim);
    end

    // Outcome in test order
    always_comb
    begin
        res_next.collides = 1'b0;
        priority if (s3_item_reg.mode)
        begin
            res_next.outcome = swdc_pkg::OC_LOAD;
        end
        else if (s3_item_reg.vclear)
        begin
            res_next.outcome = swdc_pkg::OC_VERT;
        end
        else if (end_clear)
        begin
            res_next.outcome = swdc_pkg::OC_END;
        end
        else if (far_clear)
        begin
            res_next.outcome = swdc_pkg::OC_FAR;
        end
        else if (|door_hit)
        begin
            res_next.outcome = swdc_pkg::OC_DOOR;
        end
        else
        begin
            res_next.outcome  = swdc_pkg::OC_HIT;
            res_next.collides = 1'b1;
        end
    end

    // Door table writes happen in item order, at the last stage
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < swdc_pkg::MAX_DOORS; d++)
        begin
            if (oq_wr && s3_item_reg.mode && (int'(s3_item_reg.door_index) == d))
            begin
                start_tab[d]  <= s3_item_reg.door_start;
                width_tab[d]  <= s3_item_reg.door_width;
                height_tab[d] <= s3_item_reg.door_height;
            end
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_mem[oq_wr_ptr_reg] <= res_next;
        end
    end

    assign empty  = (oq_count_reg == '0);
    assign oq_rd  = pop && !empty;
    assign result = oq_mem[oq_rd_ptr_reg];

    // Result queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (oq_wr)
            begin
                oq_wr_ptr_reg <= (oq_wr_ptr_reg == swdc_pkg::OPTR_W'(swdc_pkg::OUTQ_DEPTH - 1))
                                 ? '0 : oq_wr_ptr_reg + 1'b1;
            end
            if (oq_rd)
            begin
                oq_rd_ptr_reg <= (oq_rd_ptr_reg == swdc_pkg::OPTR_W'(swdc_pkg::OUTQ_DEPTH - 1))
                                 ? '0 : oq_rd_ptr_reg + 1'b1;
            end
            if (oq_wr && !oq_rd)
            begin
                oq_count_reg <= oq_count_reg + 1'b1;
            end
            else if (oq_rd && !oq_wr)
            begin
                oq_count_reg <= oq_count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/sphere_wall_doorway_collision.sv -----
// Top level of the sphere against doorway wall collision block with its register port.
// Sphere against doorway wall collision. A test item (mode 0) checks a sphere against a
// vertical wall and returns collides plus the reason: above or below, past an end, too far
// from the wall, through a doorway, or hit. A load item (mode 1) writes one door entry and
// returns outcome 5; loads and tests take effect strictly in the order they are pushed.
// One item is taken per clock when the result side keeps popping. A result reaches the
// result ports through the front stage register, the item queue, the three back stages and
// the result queue in that order; the front stage loads at the edge that takes the item.
// The back pipeline stalls as a whole only when its four-entry result queue is full, so
// full rises once the four-entry item queue and the front stage are backed up too.
// Registers sit at byte addresses 4*i and may only be written while the block is idle.
module sphere_wall_doorway_collision
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swdc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Item side
    input  logic                        push,
    output logic                        full,
    input  logic                        mode,
    input  logic [2:0]                  door_index,
    input  logic [30:0]                 door_start,
    input  logic [30:0]                 door_width,
    input  logic signed [31:0]          door_height,
    input  logic signed [31:0]          sphere_x,
    input  logic signed [31:0]          sphere_y,
    input  logic signed [31:0]          sphere_z,
    input  logic [30:0]                 sphere_radius,
    // Result side
    output logic                        empty,
    input  logic                        pop,
    output logic                        collides,
    output logic [2:0]                  outcome
);

    swdc_pkg::cfg_t    cfg_reg;
    logic [2:0]        reg_idx;
    logic              wr_en;
    swdc_pkg::qwr_t    qwr;
    swdc_pkg::item_t   front_item;
    swdc_pkg::item_t   q_item;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    swdc_pkg::result_t result;

    assign pready  = 1'b1;
    assign reg_idx = paddr[swdc_pkg::CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.base_y     <= '0;
            cfg_reg.origin_z   <= '0;
            cfg_reg.dir_cos    <= 16'sd16384;
            cfg_reg.dir_sin    <= '0;
            cfg_reg.length     <= '0;
            cfg_reg.height     <= '0;
            cfg_reg.door_count <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                swdc_pkg::REG_ORIGIN_X:   cfg_reg.origin_x   <= pwdata;
                swdc_pkg::REG_BASE_Y:     cfg_reg.base_y     <= pwdata;
                swdc_pkg::REG_ORIGIN_Z:   cfg_reg.origin_z   <= pwdata;
                swdc_pkg::REG_DIR_COS:    cfg_reg.dir_cos    <= pwdata[15:0];
                swdc_pkg::REG_DIR_SIN:    cfg_reg.dir_sin    <= pwdata[15:0];
                swdc_pkg::REG_LENGTH:     cfg_reg.length     <= pwdata[30:0];
                swdc_pkg::REG_HEIGHT:     cfg_reg.height     <= pwdata[30:0];
                swdc_pkg::REG_DOOR_COUNT: cfg_reg.door_count <= pwdata[3:0];
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            swdc_pkg::REG_ORIGIN_X:   prdata = cfg_reg.origin_x;
            swdc_pkg::REG_BASE_Y:     prdata = cfg_reg.base_y;
            swdc_pkg::REG_ORIGIN_Z:   prdata = cfg_reg.origin_z;
            swdc_pkg::REG_DIR_COS:    prdata = 32'(cfg_reg.dir_cos);
            swdc_pkg::REG_DIR_SIN:    prdata = 32'(cfg_reg.dir_sin);
            swdc_pkg::REG_LENGTH:     prdata = {1'b0, cfg_reg.length};
            swdc_pkg::REG_HEIGHT:     prdata = {1'b0, cfg_reg.height};
            swdc_pkg::REG_DOOR_COUNT: prdata = {28'b0, cfg_reg.door_count};
        endcase
    end

    // Front: accept and height test
    swdc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .door_index    (door_index),
        .door_start    (door_start),
        .door_width    (door_width),
        .door_height   (door_height),
        .sphere_x      (sphere_x),
        .sphere_y      (sphere_y),
        .sphere_z      (sphere_z),
        .sphere_radius (sphere_radius),
        .qwr_out       (qwr),
        .q_full        (q_full),
        .item          (front_item)
    );

    // Item queue between front and back
    swdc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (qwr.push),
        .wr_item (front_item),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (q_item)
    );

    // Back: geometry, doors, results
    swdc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_item  (q_item),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign collides = result.collides;
    assign outcome  = result.outcome;

endmodule

// ----- src/swdc_checker.sv -----
// Port-level checks for the collision block, bound to its top level.
`include "sphere_wall_doorway_collision_defines.svh"

module swdc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [swdc_pkg::CFG_AW-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready,
    input logic                        empty,
    input logic                        pop,
    input logic                        collides,
    input logic [2:0]                  outcome
);

    logic [swdc_pkg::CFG_AW-1:0] count_addr;
    logic                        cfg_wr;

    assign count_addr = {swdc_pkg::REG_DOOR_COUNT, 2'b00};
    assign cfg_wr     = psel && penable && pwrite && pready;

    // Collides flag agrees with the reason code
    `SWDC_ASSERT_NOW(a_collides_code, !empty, collides == (outcome == swdc_pkg::OC_HIT), "collides disagrees with outcome")

    // Only defined reason codes leave the block
    `SWDC_ASSERT_NOW(a_outcome_range, !empty, outcome <= swdc_pkg::OC_LOAD, "undefined outcome code")

    // A waiting result holds until its transfer
    `SWDC_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(collides) && $stable(outcome), "waiting result changed")

    // Door count written is read back masked to four bits
    `SWDC_ASSERT_NEXT(a_count_readback, cfg_wr && (paddr == count_addr), (paddr != count_addr) || (prdata == (32'h0000000F & $past(pwdata))), "door count readback mismatch")

endmodule

bind sphere_wall_doorway_collision swdc_checker u_swdc_checker (.*);

// ----- test/tb_top.sv -----
// Testbench for the sphere against doorway wall collision block: directed and random queries.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE         = 64'sd65536;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint U31_MAX     = 64'sd2147483647;
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     RANDOM_PHASES = 10;
    localparam int     ITEMS_PER_PHASE = 48;

    // One input item as pushed into the block
    typedef struct {
        logic        mode;
        logic [2:0]  door_index;
        logic [30:0] door_start;
        logic [30:0] door_width;
        logic [31:0] door_height;
        logic [31:0] sphere_x;
        logic [31:0] sphere_y;
        logic [31:0] sphere_z;
        logic [30:0] sphere_radius;
    } wall_query_t;

    // Expected answer for one item
    typedef struct {
        logic               hit;
        swdc_pkg::outcome_t reason;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [swdc_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic        mode = 1'b0;
    logic [2:0]  door_index = '0;
    logic [30:0] door_start = '0;
    logic [30:0] door_width = '0;
    logic signed [31:0] door_height = '0;
    logic signed [31:0] sphere_x = '0;
    logic signed [31:0] sphere_y = '0;
    logic signed [31:0] sphere_z = '0;
    logic [30:0] sphere_radius = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        collides;
    logic [2:0]  outcome;

    // Wall settings as last written
    logic [31:0] cfg_origin_x = '0;
    logic [31:0] cfg_base_y = '0;
    logic [31:0] cfg_origin_z = '0;
    logic [15:0] cfg_cos = 16'd16384;
    logic [15:0] cfg_sin = '0;
    logic [30:0] cfg_length = '0;
    logic [30:0] cfg_height = '0;
    logic [3:0]  cfg_doors = '0;

    // Door tables as the block should hold them
    logic [30:0] door_start_mem [swdc_pkg::MAX_DOORS];
    logic [30:0] door_width_mem [swdc_pkg::MAX_DOORS];
    logic [31:0] door_height_mem [swdc_pkg::MAX_DOORS];

    wall_query_t query_q [$];
    verdict_t    verdict_q [$];
    wall_query_t held;
    int          send_gap = 0;
    int          pop_gap = 0;
    bit          gaps_on = 1'b1;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    sphere_wall_doorway_collision u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .door_index    (door_index),
        .door_start    (door_start),
        .door_width    (door_width),
        .door_height   (door_height),
        .sphere_x      (sphere_x),
        .sphere_y      (sphere_y),
        .sphere_z      (sphere_z),
        .sphere_radius (sphere_radius),
        .empty         (empty),
        .pop           (pop),
        .collides      (collides),
        .outcome       (outcome)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Append one item to the pending stimulus
    task automatic add_query(input wall_query_t q);
        query_q.insert(query_q.size(), q);
    endtask

    // Random value in [lo, hi]
    function automatic longint rand_between(input longint lo, input longint hi);
        longint unsigned span;
        longint unsigned pick;
        if (hi <= lo)
            return lo;
        span = longint'(hi - lo) + 1;
        pick = {$urandom, $urandom};
        return lo + longint'(pick % span);
    endfunction

    // Gap before the next transfer: mostly none, some short, a few long
    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_on || p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sphere test outcome for the current wall and door tables
    function automatic swdc_pkg::outcome_t classify_sphere(input wall_query_t q);
        longint sx, sy, sz, r, rs, base, c, s, len, hgt;
        longint dx, dz, along, across, st, wd, hd;
        int n;
        sx   = $signed(q.sphere_x);
        sy   = $signed(q.sphere_y);
        sz   = $signed(q.sphere_z);
        r    = q.sphere_radius;
        rs   = r * 16384;
        base = $signed(cfg_base_y);
        c    = $signed(cfg_cos);
        s    = $signed(cfg_sin);
        len  = cfg_length;
        hgt  = cfg_height;

        if (sy + r < base || sy - r > base + hgt)
            return swdc_pkg::OC_VERT;

        dx    = sx - longint'($signed(cfg_origin_x));
        dz    = sz - longint'($signed(cfg_origin_z));
        along = c * dx + s * dz;
        if (along < -rs || along > (len + r) * 16384)
            return swdc_pkg::OC_END;

        across = c * dz - s * dx;
        if (across < 0)
            across = -across;
        if (across > rs)
            return swdc_pkg::OC_FAR;

        // Counts above the table depth use every entry
        n = (cfg_doors > swdc_pkg::MAX_DOORS) ? swdc_pkg::MAX_DOORS : int'(cfg_doors);
        for (int d = 0; d < n; d++)
        begin
            st = door_start_mem[d];
            wd = door_width_mem[d];
            hd = $signed(door_height_mem[d]);
            if (along > st * 16384 && along < (st + wd) * 16384 && sy < hd - r)
                return swdc_pkg::OC_DOOR;
        end
        return swdc_pkg::OC_HIT;
    endfunction

    // Answer for one accepted item; a load updates the door tables
    function automatic verdict_t judge_query(input wall_query_t q);
        verdict_t v;
        if (q.mode)
        begin
            door_start_mem[q.door_index]  = q.door_start;
            door_width_mem[q.door_index]  = q.door_width;
            door_height_mem[q.door_index] = q.door_height;
            v.hit    = 1'b0;
            v.reason = swdc_pkg::OC_LOAD;
        end
        else
        begin
            v.reason = classify_sphere(q);
            v.hit    = (v.reason == swdc_pkg::OC_HIT);
        end
        return v;
    endfunction

    // Item builders; the fields a mode ignores are random
    function automatic wall_query_t make_sphere(input longint x, input longint y,
                                                input longint z, input longint r);
        wall_query_t q;
        q.mode          = 1'b0;
        q.door_index    = 3'($urandom);
        q.door_start    = 31'($urandom);
        q.door_width    = 31'($urandom);
        q.door_height   = $urandom;
        q.sphere_x      = 32'(x);
        q.sphere_y      = 32'(y);
        q.sphere_z      = 32'(z);
        q.sphere_radius = 31'(r);
        return q;
    endfunction

    function automatic wall_query_t make_door(input int idx, input longint st,
                                              input longint wd, input longint ht);
        wall_query_t q;
        q.mode          = 1'b1;
        q.door_index    = 3'(idx);
        q.door_start    = 31'(st);
        q.door_width    = 31'(wd);
        q.door_height   = 32'(ht);
        q.sphere_x      = $urandom;
        q.sphere_y      = $urandom;
        q.sphere_z      = $urandom;
        q.sphere_radius = 31'($urandom);
        return q;
    endfunction

    function automatic wall_query_t noise_query();
        wall_query_t q;
        q = make_sphere($urandom, $urandom, $urandom, $urandom);
        q.mode = 1'($urandom_range(0, 1));
        return q;
    endfunction

    function automatic longint pick_radius();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return 0;
        if (p < 85)
            return rand_between(1, ONE * 16);
        return rand_between(ONE * 16, U31_MAX);
    endfunction

    // Sphere at distance t along and a across the wall, centre height y
    function automatic wall_query_t place_sphere(input longint t, input longint a,
                                                 input longint y, input longint r);
        longint c, s, x, z;
        c = $signed(cfg_cos);
        s = $signed(cfg_sin);
        x = longint'($signed(cfg_origin_x)) + ((c * t - s * a) >>> 14);
        z = longint'($signed(cfg_origin_z)) + ((s * t + c * a) >>> 14);
        return make_sphere(x, y, z, r);
    endfunction

    function automatic wall_query_t near_wall_query();
        longint r, t, a, y, base;
        r    = pick_radius();
        base = $signed(cfg_base_y);
        t    = rand_between(-r - ONE * 4, longint'(cfg_length) + r + ONE * 4);
        a    = rand_between(-(r + r / 4 + 64), r + r / 4 + 64);
        y    = base + rand_between(-r - ONE * 4, longint'(cfg_height) + r + ONE * 4);
        return place_sphere(t, a, y, r);
    endfunction

    // Sphere aimed at one door in use, around its edges and height limit
    function automatic wall_query_t doorway_query();
        int n, d;
        longint r, t, a, y, st, wd, hd;
        n  = (cfg_doors > swdc_pkg::MAX_DOORS) ? swdc_pkg::MAX_DOORS : int'(cfg_doors);
        d  = $urandom_range(0, n - 1);
        st = door_start_mem[d];
        wd = door_width_mem[d];
        hd = $signed(door_height_mem[d]);
        r  = rand_between(0, ONE * 2);
        t  = rand_between(st - ONE, st + wd + ONE);
        a  = rand_between(-r, r);
        y  = rand_between(hd - r - ONE * 2, hd - r + ONE / 2);
        return place_sphere(t, a, y, r);
    endfunction

    function automatic wall_query_t random_load();
        longint len, base;
        len  = cfg_length;
        base = $signed(cfg_base_y);
        if ($urandom_range(0, 4) == 0)
            return make_door($urandom_range(0, 7), $urandom, $urandom, $urandom);
        return make_door($urandom_range(0, 7), rand_between(0, len),
                         rand_between(0, len / 3 + ONE),
                         base + rand_between(-ONE, longint'(cfg_height) + ONE));
    endfunction

    function automatic wall_query_t random_query();
        int p;
        p = $urandom_range(0, 99);
        if (p < 12)
            return random_load();
        if (p < 25)
            return noise_query();
        if (p < 55 && cfg_doors != 0)
            return doorway_query();
        return near_wall_query();
    endfunction

    // One register write: setup then access
    task automatic write_reg(input logic [2:0] idx, input longint value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            swdc_pkg::REG_ORIGIN_X:   cfg_origin_x = 32'(value);
            swdc_pkg::REG_BASE_Y:     cfg_base_y   = 32'(value);
            swdc_pkg::REG_ORIGIN_Z:   cfg_origin_z = 32'(value);
            swdc_pkg::REG_DIR_COS:    cfg_cos      = 16'(value);
            swdc_pkg::REG_DIR_SIN:    cfg_sin      = 16'(value);
            swdc_pkg::REG_LENGTH:     cfg_length   = 31'(value);
            swdc_pkg::REG_HEIGHT:     cfg_height   = 31'(value);
            swdc_pkg::REG_DOOR_COUNT: cfg_doors    = 4'(value);
            default: ;
        endcase
    endtask

    task automatic set_wall(input longint ox, input longint by, input longint oz,
                            input longint c, input longint s, input longint len,
                            input longint hgt, input longint n);
        write_reg(swdc_pkg::REG_ORIGIN_X, ox);
        write_reg(swdc_pkg::REG_BASE_Y, by);
        write_reg(swdc_pkg::REG_ORIGIN_Z, oz);
        write_reg(swdc_pkg::REG_DIR_COS, c);
        write_reg(swdc_pkg::REG_DIR_SIN, s);
        write_reg(swdc_pkg::REG_LENGTH, len);
        write_reg(swdc_pkg::REG_HEIGHT, hgt);
        write_reg(swdc_pkg::REG_DOOR_COUNT, n);
        @(negedge clk);
    endtask

    task automatic random_wall();
        longint c, s;
        case ($urandom_range(0, 6))
            0: begin c = 16384;  s = 0;      end
            1: begin c = 0;      s = 16384;  end
            2: begin c = -16384; s = 0;      end
            3: begin c = 0;      s = -16384; end
            4: begin c = 11585;  s = 11585;  end
            5: begin c = -11585; s = 11585;  end
            default: begin c = 15137; s = -6270; end
        endcase
        set_wall(rand_between(-ONE * 256, ONE * 256), rand_between(-ONE * 64, ONE * 64),
                 rand_between(-ONE * 256, ONE * 256), c, s,
                 rand_between(ONE, ONE * 128), rand_between(ONE, ONE * 64),
                 $urandom_range(0, 15));
    endtask

    // Wait until every item has been taken and every answer has come back
    task automatic wait_drained();
        while (query_q.size() != 0 || verdict_q.size() != 0 || push)
            @(negedge clk);
    endtask

    // Item driver: one transfer per accepted edge, random gaps between
    always @(posedge clk)
    begin : drive_items
        bit send;
        send = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                verdict_q.insert(verdict_q.size(), judge_query(held));
                send_gap = idle_gap();
            end
            if (!push || !full)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (query_q.size() != 0)
                    send = 1'b1;
                if (send)
                begin
                    held = query_q.pop_front();
                    mode          <= held.mode;
                    door_index    <= held.door_index;
                    door_start    <= held.door_start;
                    door_width    <= held.door_width;
                    door_height   <= held.door_height;
                    sphere_x      <= held.sphere_x;
                    sphere_y      <= held.sphere_y;
                    sphere_z      <= held.sphere_z;
                    sphere_radius <= held.sphere_radius;
                end
                push <= send;
            end
        end
    end

    // Result monitor: check each transfer against the oldest expectation
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    want = verdict_q.pop_front();
                    if (collides !== want.hit)
                        report_mismatch($sformatf("collides %b, expected %b",
                                                  collides, want.hit));
                    if (outcome !== want.reason)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  outcome, want.reason));
                end
                pop_gap = idle_gap();
            end
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Stimulus sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Plain wall along x, 100 long and 50 high, no doors in use yet
        set_wall(0, 0, 0, 16384, 0, ONE * 100, ONE * 50, 0);
        add_query(make_door(0, ONE * 10, ONE * 20, ONE * 30));
        add_query(make_door(1, ONE * 40, ONE * 5, ONE * 20));
        add_query(make_door(2, ONE * 80, ONE * 10, ONE * 45));
        add_query(make_door(3, 0, ONE * 3, ONE * 10));
        add_query(make_door(4, ONE * 90, ONE * 10, -ONE * 5));
        add_query(make_door(5, U31_MAX, U31_MAX, S32_MAX));
        add_query(make_door(6, 0, 0, S32_MIN));
        add_query(make_door(7, ONE * 60, ONE * 10, S32_MAX));
        add_query(make_sphere(ONE * 50, -ONE * 10, 0, ONE));
        add_query(make_sphere(ONE * 50, ONE * 60, 0, ONE));
        add_query(make_sphere(-ONE * 5, ONE * 10, 0, ONE));
        add_query(make_sphere(ONE * 110, ONE * 10, 0, ONE));
        add_query(make_sphere(ONE * 50, ONE * 10, ONE * 5, ONE));
        add_query(make_sphere(ONE * 50, ONE * 10, 0, ONE));
        add_query(make_sphere(ONE * 50, ONE * 10, 0, 0));
        // bottom of the sphere just touching the base
        add_query(make_sphere(ONE * 50, -ONE, 0, ONE));
        add_query(make_sphere(S32_MIN, S32_MAX, S32_MIN, U31_MAX));
        add_query(make_sphere(S32_MAX, S32_MIN, S32_MAX, 0));
        wait_drained();

        // All doors in use: through a doorway, on its edge, too tall, negative limit
        write_reg(swdc_pkg::REG_DOOR_COUNT, 8);
        @(negedge clk);
        add_query(make_sphere(ONE * 20, ONE * 10, 0, ONE));
        add_query(make_sphere(ONE * 10, ONE * 10, 0, ONE));
        add_query(make_sphere(ONE * 20, ONE * 29 + ONE / 2, 0, ONE));
        add_query(make_sphere(ONE * 65, ONE * 40, 0, ONE));
        add_query(make_sphere(ONE * 95, ONE * 10, 0, ONE));
        wait_drained();

        // Door count beyond the table depth
        write_reg(swdc_pkg::REG_DOOR_COUNT, 15);
        @(negedge clk);
        add_query(make_sphere(ONE * 20, ONE * 10, 0, ONE));
        add_query(make_sphere(ONE * 65, ONE * 40, ONE / 2, ONE));
        wait_drained();

        // Random phases, a few with extreme or non-unit wall settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            gaps_on = (ph % 4) != 2;
            case (ph)
                1: set_wall(S32_MIN, S32_MIN, S32_MIN, -16384, 0, U31_MAX, U31_MAX, 8);
                4: set_wall(S32_MAX, S32_MAX, S32_MAX, 0, 16384, 0, 0, 15);
                7: set_wall(rand_between(-ONE * 64, ONE * 64), 0, 0, -32768, 32767,
                            ONE * 40, ONE * 20, 1);
                default: random_wall();
            endcase
            repeat (ITEMS_PER_PHASE)
                add_query(random_query());
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
